[sv/tmcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_pkg
// Shared constants, types and codes of the text-mode console writer.
// ----------------------------------------------------------------------------
package tmcw_pkg;

	// screen geometry
	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLUMNS);
	// width of row * COLUMNS + column for any 8-bit row and column
	localparam int WIDE_W = $clog2(255 * COLUMNS + 256);

	// port field widths
	localparam int REQ_W     = 2;
	localparam int BYTE_W    = 8;
	localparam int CELL_W    = 16;
	localparam int OUT_ROW_W = 5;
	localparam int OUT_COL_W = 7;
	localparam int OUT_OFF_W = 11;

	localparam logic [BYTE_W-1:0] BLANK_CHAR     = 8'd32;
	localparam logic [BYTE_W-1:0] NEWLINE_CHAR   = 8'd10;
	localparam logic [BYTE_W-1:0] TEXT_COLOR_RST = 8'd7;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_SCROLL = 1'd1;

	// command queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [REQ_W-1:0] {
		OP_PUT_CHAR = 2'd0,
		OP_PUT_AT   = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_READ     = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              is_nl;
		logic [BYTE_W-1:0] ch;
		logic [BYTE_W-1:0] color;
		logic [ADDR_W-1:0] addr;
	} q_item_t;

	typedef struct packed {
		logic init_busy;
	} back_stat_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_READ,
		BK_COPY,
		BK_COPY_LAST,
		BK_FILL
	} bk_state_t;

endpackage

[sv/tmcw_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_req_if
// Request channel: operation code, character, color and position.
// ----------------------------------------------------------------------------
interface tmcw_req_if;
	import tmcw_pkg::*;

	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [BYTE_W-1:0]   char_code;
	logic [BYTE_W-1:0]   cell_color;
	logic [BYTE_W-1:0]   cell_row;
	logic [BYTE_W-1:0]   cell_column;

	modport source (
		output valid, req_type, char_code, cell_color, cell_row, cell_column,
		input  ready
	);
	modport sink (
		input  valid, req_type, char_code, cell_color, cell_row, cell_column,
		output ready
	);
endinterface

[sv/tmcw_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_rsp_if
// Result channel: cursor position and offset, read data, scroll flag.
// ----------------------------------------------------------------------------
interface tmcw_rsp_if;
	import tmcw_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OUT_ROW_W-1:0] cursor_row;
	logic [OUT_COL_W-1:0] cursor_column;
	logic [OUT_OFF_W-1:0] cursor_offset;
	logic [CELL_W-1:0]    read_data;
	logic                 scrolled;

	modport source (
		output valid, cursor_row, cursor_column, cursor_offset, read_data, scrolled,
		input  ready
	);
	modport sink (
		input  valid, cursor_row, cursor_column, cursor_offset, read_data, scrolled,
		output ready
	);
endinterface

[sv/tmcw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

[sv/tmcw_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_front
// Accept requests, map positions to cell addresses, queue them for the back.
// ----------------------------------------------------------------------------
module tmcw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	tmcw_req_if.sink             req,
	input  tmcw_pkg::back_stat_t stat,
	output logic                 q_valid,
	output tmcw_pkg::q_item_t    q_item,
	input  logic                 q_pop
);
	import tmcw_pkg::*;

	q_item_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic [WIDE_W-1:0]   lin_off;
	q_item_t             new_item;
	logic                push;

	// linear offset; anything past the screen lands on cell 0
	always_comb begin
		lin_off = WIDE_W'(req.cell_row) * WIDE_W'(COLUMNS) + WIDE_W'(req.cell_column);
		new_item.op    = op_t'(req.req_type);
		new_item.is_nl = (req.char_code == NEWLINE_CHAR);
		new_item.ch    = req.char_code;
		new_item.color = req.cell_color;
		new_item.addr  = (lin_off >= WIDE_W'(CELL_COUNT)) ? '0 : ADDR_W'(lin_off);
	end

	assign req.ready = !stat.init_busy && (count_q < QCNT_W'(QDEPTH));
	assign push      = req.valid && req.ready;
	assign q_valid   = (count_q != '0);
	assign q_item    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

[sv/tmcw_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcw_back
// Execute queued commands against the screen RAM, own the cursor and the
// result register; run the fill and scroll walks.
// ----------------------------------------------------------------------------
module tmcw_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  tmcw_pkg::q_item_t             q_item,
	output logic                          q_pop,
	output tmcw_pkg::back_stat_t          stat,
	input  logic [tmcw_pkg::BYTE_W-1:0]   text_color,
	input  logic                          auto_scroll,
	tmcw_rsp_if.source                    rsp
);
	import tmcw_pkg::*;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] LAST_ROW0 = ADDR_W'(CELL_COUNT - COLUMNS);

	bk_state_t          state_q, state_d;
	logic [ADDR_W-1:0]  walk_q, walk_d;
	logic [BYTE_W-1:0]  fill_color_q, fill_color_d;
	logic               scroll_q, scroll_d;
	logic               init_q, init_d;
	logic [ROW_W-1:0]   cur_row_q, cur_row_d;
	logic [COL_W-1:0]   cur_col_q, cur_col_d;
	logic [ADDR_W-1:0]  cur_off_q, cur_off_d;
	logic               copy_vld_s1;
	logic [ADDR_W-1:0]  copy_dst_s1;

	logic               rsp_vld_q;
	logic [OUT_ROW_W-1:0] out_row_q;
	logic [OUT_COL_W-1:0] out_col_q;
	logic [OUT_OFF_W-1:0] out_off_q;
	logic [CELL_W-1:0]  out_rdata_q;
	logic               out_scr_q;

	logic               wr_en, rd_en;
	logic [ADDR_W-1:0]  wr_addr, rd_addr;
	logic [CELL_W-1:0]  wr_data, rd_data;

	logic               slot_free, issue;
	logic               wrap, last_row, need_scroll;
	logic [ROW_W-1:0]   adv_row;
	logic [COL_W-1:0]   adv_col;
	logic [ADDR_W-1:0]  adv_off;
	logic               res_load, res_scrolled;
	logic [CELL_W-1:0]  res_rdata;

	tmcw_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign slot_free      = !rsp_vld_q || rsp.ready;
	assign issue          = (state_q == BK_IDLE) && q_valid && slot_free;
	assign stat.init_busy = init_q;

	// cursor advance for put char
	always_comb begin
		wrap        = q_item.is_nl || (cur_col_q == COL_W'(COLUMNS - 1));
		last_row    = (cur_row_q == ROW_W'(ROWS - 1));
		need_scroll = wrap && last_row && auto_scroll;
		adv_row     = cur_row_q;
		adv_col     = cur_col_q + 1'b1;
		adv_off     = cur_off_q + 1'b1;
		if (wrap) begin
			adv_col = '0;
			if (!last_row) begin
				adv_row = cur_row_q + 1'b1;
				adv_off = cur_off_q - ADDR_W'(cur_col_q) + ROW_SPAN;
			end else if (auto_scroll) begin
				adv_off = LAST_ROW0;
			end else begin
				adv_row = '0;
				adv_off = '0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (issue) begin
					unique case (q_item.op)
						OP_PUT_CHAR: state_d = need_scroll ? BK_COPY : BK_IDLE;
						OP_PUT_AT:   state_d = BK_IDLE;
						OP_CLEAR:    state_d = BK_FILL;
						OP_READ:     state_d = BK_READ;
					endcase
				end
			end
			BK_READ:      state_d = BK_IDLE;
			BK_COPY:      state_d = (walk_q == LAST_ADDR) ? BK_COPY_LAST : BK_COPY;
			BK_COPY_LAST: state_d = BK_FILL;
			BK_FILL:      state_d = (walk_q == LAST_ADDR) ? BK_IDLE : BK_FILL;
			default:      state_d = BK_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		q_pop        = 1'b0;
		wr_en        = 1'b0;
		wr_addr      = walk_q;
		wr_data      = {fill_color_q, BLANK_CHAR};
		rd_en        = 1'b0;
		rd_addr      = walk_q;
		walk_d       = walk_q;
		fill_color_d = fill_color_q;
		scroll_d     = scroll_q;
		init_d       = init_q;
		cur_row_d    = cur_row_q;
		cur_col_d    = cur_col_q;
		cur_off_d    = cur_off_q;
		res_load     = 1'b0;
		res_rdata    = '0;
		res_scrolled = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (issue) begin
					q_pop = 1'b1;
					unique case (q_item.op)
						OP_PUT_CHAR: begin
							wr_en     = !q_item.is_nl;
							wr_addr   = cur_off_q;
							wr_data   = {text_color, q_item.ch};
							cur_row_d = adv_row;
							cur_col_d = adv_col;
							cur_off_d = adv_off;
							if (need_scroll) begin
								scroll_d = 1'b1;
								walk_d   = ROW_SPAN;
							end else begin
								res_load = 1'b1;
							end
						end
						OP_PUT_AT: begin
							wr_en    = 1'b1;
							wr_addr  = q_item.addr;
							wr_data  = {q_item.color, q_item.ch};
							res_load = 1'b1;
						end
						OP_CLEAR: begin
							walk_d       = '0;
							fill_color_d = text_color;
							scroll_d     = 1'b0;
						end
						OP_READ: begin
							rd_en   = 1'b1;
							rd_addr = q_item.addr;
						end
					endcase
				end
			end
			BK_READ: begin
				res_load  = 1'b1;
				res_rdata = rd_data;
			end
			BK_COPY: begin
				// read a row below, write back what the previous cycle read
				rd_en   = 1'b1;
				walk_d  = walk_q + 1'b1;
				wr_en   = copy_vld_s1;
				wr_addr = copy_dst_s1;
				wr_data = rd_data;
			end
			BK_COPY_LAST: begin
				wr_en        = 1'b1;
				wr_addr      = copy_dst_s1;
				wr_data      = rd_data;
				walk_d       = LAST_ROW0;
				fill_color_d = text_color;
			end
			BK_FILL: begin
				wr_en  = 1'b1;
				walk_d = walk_q + 1'b1;
				if (walk_q == LAST_ADDR) begin
					if (init_q) begin
						init_d = 1'b0;
					end else begin
						res_load     = 1'b1;
						res_scrolled = scroll_q;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_FILL;
			walk_q       <= '0;
			fill_color_q <= TEXT_COLOR_RST;
			scroll_q     <= 1'b0;
			init_q       <= 1'b1;
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			cur_off_q    <= '0;
			copy_vld_s1  <= 1'b0;
			rsp_vld_q    <= 1'b0;
		end else begin
			state_q      <= state_d;
			walk_q       <= walk_d;
			fill_color_q <= fill_color_d;
			scroll_q     <= scroll_d;
			init_q       <= init_d;
			cur_row_q    <= cur_row_d;
			cur_col_q    <= cur_col_d;
			cur_off_q    <= cur_off_d;
			copy_vld_s1  <= (state_q == BK_COPY);
			if (res_load) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		copy_dst_s1 <= walk_q - ROW_SPAN;
		if (res_load) begin
			out_row_q   <= OUT_ROW_W'(cur_row_d);
			out_col_q   <= OUT_COL_W'(cur_col_d);
			out_off_q   <= OUT_OFF_W'(cur_off_d);
			out_rdata_q <= res_rdata;
			out_scr_q   <= res_scrolled;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.cursor_row    = out_row_q;
	assign rsp.cursor_column = out_col_q;
	assign rsp.cursor_offset = out_off_q;
	assign rsp.read_data     = out_rdata_q;
	assign rsp.scrolled      = out_scr_q;
endmodule

[sv/text_mode_console_writer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_writer_core
// Text-mode console engine: a ROWS x COLUMNS screen of 16-bit cells (color
// in the high byte, character in the low byte) with a cursor.
// ----------------------------------------------------------------------------
//
//   channel   dir   transaction on      payload
//   req       in    valid & ready       req_type, char_code, cell_color,
//                                       cell_row, cell_column
//   rsp       out   valid & ready       cursor_row, cursor_column,
//                                       cursor_offset, read_data, scrolled
//   cfg       in    cfg_we              cfg_idx, cfg_wdata
//
// Put char without scroll and put entry complete in the back end's idle
// state, so plain text runs at one transaction a cycle while the result
// register is free or rsp takes its result. Read cell passes through the
// registered RAM read port and the BK_READ state. Clear walks the screen RAM
// write port, one cell a cycle. A scrolling put char copies through the
// single read and write ports, one cell a cycle, then blanks the last row.
// After reset the back end blanks the screen in color 7 with req.ready held
// low; configuration writes are taken meanwhile.
// A two-entry queue sits between front and back, and a result register
// decouples rsp, so requests are still taken while a result waits.
//
module text_mode_console_writer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	tmcw_req_if.sink                            req,
	tmcw_rsp_if.source                          rsp,
	input  logic                                cfg_we,
	input  logic [tmcw_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [tmcw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import tmcw_pkg::*;

	logic [BYTE_W-1:0] text_color_q;
	logic              auto_scroll_q;

	logic              q_valid;
	q_item_t           q_item;
	logic              q_pop;
	back_stat_t        stat;

	// configuration registers; hold their value between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q  <= TEXT_COLOR_RST;
			auto_scroll_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_TEXT_COLOR:  text_color_q  <= cfg_wdata[BYTE_W-1:0];
				CFG_AUTO_SCROLL: auto_scroll_q <= cfg_wdata[0];
			endcase
		end
	end

	// front: accept, decode the position into a cell address, queue
	tmcw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.stat    (stat),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// back: cursor, screen RAM, fill and scroll walks, result register
	tmcw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.stat        (stat),
		.text_color  (text_color_q),
		.auto_scroll (auto_scroll_q),
		.rsp         (rsp)
	);
endmodule

[test/text_mode_console_writer_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_console_writer_core_tb
// Self-checking bench for the console writer core. A scoreboard keeps its own
// copy of the screen, the cursor and both registers. It predicts the cursor
// report for every accepted request and checks the reports in order. Stimulus
// is a short directed run, then random text lines mixed with cell writes,
// cell reads, clears and noise, in several register settings. Both channels
// idle in random bursts.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core_tb;
	import tmcw_pkg::*;

	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 12;
	localparam int PHASE_COUNT  = 6;
	localparam int PHASE_ITEMS  = 240;
	localparam int HOLD_CYCLES  = 64;
	// a scroll is the longest operation: let one more pass by after the last report
	localparam int DRAIN_CYCLES = 2 * CELL_COUNT + 32;
	localparam int CYCLE_LIMIT  = 20_000_000;

	typedef struct packed {
		op_t               op;
		logic [BYTE_W-1:0] ch;
		logic [BYTE_W-1:0] color;
		logic [BYTE_W-1:0] row;
		logic [BYTE_W-1:0] column;
	} console_req_t;

	typedef struct packed {
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] column;
		logic [OUT_OFF_W-1:0] offset;
		logic [CELL_W-1:0]    rdata;
		logic                 scrolled;
	} cursor_report_t;

	// Screen mirror plus the queue of cursor reports still owed by the block.
	class screen_scoreboard;
		logic [CELL_W-1:0] cells [CELL_COUNT];
		int unsigned       cur_row;
		int unsigned       cur_col;
		logic [BYTE_W-1:0] text_color;
		logic              auto_scroll;
		cursor_report_t    pending_reports [$];
		int unsigned       mismatches;

		function new();
			text_color  = TEXT_COLOR_RST;
			auto_scroll = 1'b0;
			cur_row     = 0;
			cur_col     = 0;
			mismatches  = 0;
			fill_blank(0, CELL_COUNT);
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_TEXT_COLOR:  text_color  = value;
				CFG_AUTO_SCROLL: auto_scroll = value[0];
				default: ;
			endcase
		endfunction

		// offsets past the end of the screen land on the first cell
		function int unsigned cell_index(int unsigned row, int unsigned column);
			int unsigned off;
			off = row * COLUMNS + column;
			if (off >= CELL_COUNT)
				off = 0;
			return off;
		endfunction

		function void fill_blank(int unsigned first, int unsigned count);
			for (int unsigned i = first; i < first + count; i++)
				cells[i] = {text_color, BLANK_CHAR};
		endfunction

		function void note_request(console_req_t item);
			cursor_report_t rpt;
			rpt = '0;
			case (item.op)
				OP_PUT_CHAR: begin
					// newline skips the write and jumps to the row end
					if (item.ch == NEWLINE_CHAR)
						cur_col = COLUMNS - 1;
					else
						cells[cell_index(cur_row, cur_col)] = {text_color, item.ch};
					cur_col++;
					if (cur_col >= COLUMNS) begin
						cur_col = 0;
						cur_row++;
						if (cur_row >= ROWS) begin
							if (auto_scroll) begin
								for (int unsigned i = 0; i < CELL_COUNT - COLUMNS; i++)
									cells[i] = cells[i + COLUMNS];
								fill_blank(CELL_COUNT - COLUMNS, COLUMNS);
								rpt.scrolled = 1'b1;
								cur_row = ROWS - 1;
							end else begin
								cur_row = 0;
							end
						end
					end
				end
				OP_PUT_AT: cells[cell_index(item.row, item.column)] = {item.color, item.ch};
				OP_CLEAR:  fill_blank(0, CELL_COUNT);
				default:   rpt.rdata = cells[cell_index(item.row, item.column)];
			endcase
			rpt.row    = cur_row[OUT_ROW_W-1:0];
			rpt.column = cur_col[OUT_COL_W-1:0];
			rpt.offset = OUT_OFF_W'(cell_index(cur_row, cur_col));
			pending_reports.push_back(rpt);
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_report(cursor_report_t got);
			cursor_report_t want;
			if (pending_reports.size() == 0) begin
				$display("%0t: unexpected report, expected none, actual row %0d col %0d data %h",
					$time, got.row, got.column, got.rdata);
				mismatches++;
				return;
			end
			want = pending_reports.pop_front();
			compare_field("cursor_row", want.row, got.row);
			compare_field("cursor_column", want.column, got.column);
			compare_field("cursor_offset", want.offset, got.offset);
			compare_field("read_data", want.rdata, got.rdata);
			compare_field("scrolled", want.scrolled, got.scrolled);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	tmcw_req_if req_ch();
	tmcw_rsp_if rsp_ch();

	screen_scoreboard sb = new();

	// knobs shared by the sender and receiver processes
	int unsigned tx_idle_pct      = 0;
	int unsigned rx_idle_pct      = 0;
	bit          quiet_tail       = 1'b0;
	bit          hold_off_request = 1'b0;
	int unsigned items_sent       = 0;
	int unsigned cycle_count      = 0;

	text_mode_console_writer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: pick ready at the falling edge, take the transaction at the
	// rising edge. A hold-off request parks ready low until hold_left, counted
	// down here, runs out, while the sender keeps pushing.
	initial begin
		int unsigned stall_left;
		int unsigned hold_left;
		cursor_report_t got;
		stall_left = 0;
		hold_left  = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready = 1'b0;
				hold_left--;
			end else if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				rsp_ch.ready = 1'b0;
			end else if (stall_left > 0) begin
				rsp_ch.ready = 1'b0;
				stall_left--;
			end else if (!quiet_tail && $urandom_range(0, 99) < rx_idle_pct) begin
				rsp_ch.ready = 1'b0;
				stall_left = $urandom_range(1, 13) - 1;
			end else begin
				rsp_ch.ready = 1'b1;
			end
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.row      = rsp_ch.cursor_row;
				got.column   = rsp_ch.cursor_column;
				got.offset   = rsp_ch.cursor_offset;
				got.rdata    = rsp_ch.read_data;
				got.scrolled = rsp_ch.scrolled;
				sb.check_report(got);
			end
		end
	end

	// Register write: only called with nothing in flight.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_idx   = idx;
		cfg_wdata = value;
		sb.write_register(idx, value);
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	// Offer one request, maybe after a random sender gap; hold it until taken.
	task automatic send_request(input op_t op, input logic [BYTE_W-1:0] ch,
			input logic [BYTE_W-1:0] color, input logic [BYTE_W-1:0] row,
			input logic [BYTE_W-1:0] column);
		console_req_t item;
		int unsigned gap;
		item = '{op: op, ch: ch, color: color, row: row, column: column};
		if (!quiet_tail && $urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, 13);
			@(negedge clk);
			req_ch.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid       = 1'b1;
		req_ch.req_type    = op;
		req_ch.char_code   = ch;
		req_ch.cell_color  = color;
		req_ch.cell_row    = row;
		req_ch.cell_column = column;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(item);
		items_sent++;
	endtask

	// Drop valid and hold until every owed report has come back.
	task automatic wait_for_reports();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (sb.pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// Positions: mostly on screen, sometimes anywhere in the byte range.
	function automatic logic [BYTE_W-1:0] pick_row();
		if ($urandom_range(0, 99) < 15)
			return BYTE_W'($urandom_range(0, 255));
		if ($urandom_range(0, 1))
			return BYTE_W'(sb.cur_row);
		return BYTE_W'($urandom_range(0, ROWS - 1));
	endfunction

	function automatic logic [BYTE_W-1:0] pick_column();
		if ($urandom_range(0, 99) < 15)
			return BYTE_W'($urandom_range(0, 255));
		return BYTE_W'($urandom_range(0, COLUMNS - 1));
	endfunction

	// Random cell write or cell read.
	task automatic send_cell_access();
		if ($urandom_range(0, 99) < 50)
			send_request(OP_READ, BYTE_W'($urandom), BYTE_W'($urandom), pick_row(),
				pick_column());
		else
			send_request(OP_PUT_AT, BYTE_W'($urandom), BYTE_W'($urandom), pick_row(),
				pick_column());
	endtask

	// A line of text ended by a newline; mostly short, sometimes past a row.
	task automatic send_text_line();
		int unsigned len;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			len = $urandom_range(0, 4);
		else if (pick < 90)
			len = $urandom_range(5, 40);
		else
			len = $urandom_range(41, 2 * COLUMNS + 8);
		for (int unsigned i = 0; i < len; i++) begin
			send_request(OP_PUT_CHAR, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom),
				BYTE_W'($urandom), BYTE_W'($urandom));
			if ($urandom_range(0, 99) < 10)
				send_cell_access();
		end
		send_request(OP_PUT_CHAR, NEWLINE_CHAR, BYTE_W'($urandom), BYTE_W'($urandom),
			BYTE_W'($urandom));
	endtask

	// Directed corners: reset contents, off-screen positions, last cell,
	// byte extremes, newline, clear.
	task automatic run_directed();
		send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(OP_PUT_AT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		send_request(OP_READ, 8'h00, 8'h00, 8'(ROWS), 8'h00);
		send_request(OP_PUT_AT, 8'h00, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 1));
		send_request(OP_READ, 8'hFF, 8'hFF, 8'(ROWS - 1), 8'(COLUMNS - 1));
		send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'hFF);
		send_request(OP_PUT_CHAR, 8'h41, 8'h00, 8'h00, 8'h00);
		send_request(OP_PUT_CHAR, 8'hFF, 8'h00, 8'h00, 8'h00);
		send_request(OP_PUT_CHAR, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(OP_PUT_CHAR, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00);
		send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'h01);
		send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'h03);
		// newline at column zero still moves a full row
		send_request(OP_PUT_CHAR, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00);
		send_request(OP_PUT_CHAR, NEWLINE_CHAR, 8'h00, 8'h00, 8'h00);
		send_request(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00);
		send_request(OP_READ, 8'h00, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 1));
	endtask

	// One random phase: mostly text lines, then cell traffic, clears and
	// noise with every field random.
	task automatic run_random_phase(input int unsigned phase_no);
		int unsigned start;
		int unsigned pick;
		bit          pressure_done;
		start = items_sent;
		pressure_done = 1'b0;
		while (items_sent - start < PHASE_ITEMS) begin
			if (!pressure_done && items_sent - start >= PHASE_ITEMS / 2) begin
				pressure_done = 1'b1;
				// stall the report side long enough to back up the request side
				if (phase_no == 1)
					hold_off_request = 1'b1;
				// let the block drain completely, then resume
				if (phase_no == 3)
					wait_for_reports();
			end
			pick = $urandom_range(0, 99);
			if (pick < 55)
				send_text_line();
			else if (pick < 93)
				send_cell_access();
			else if (pick < 97)
				send_request(OP_CLEAR, BYTE_W'($urandom), BYTE_W'($urandom),
					BYTE_W'($urandom), BYTE_W'($urandom));
			else
				repeat ($urandom_range(1, 5))
					send_request(op_t'($urandom_range(0, 3)), BYTE_W'($urandom),
						BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] color;
		logic                  scroll;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = CFG_TEXT_COLOR;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = OP_PUT_CHAR;
		req_ch.char_code   = '0;
		req_ch.cell_color  = '0;
		req_ch.cell_row    = '0;
		req_ch.cell_column = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// directed run in the reset settings, light idling on both sides
		write_register(CFG_TEXT_COLOR, TEXT_COLOR_RST);
		write_register(CFG_AUTO_SCROLL, 8'd0);
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		run_directed();
		wait_for_reports();

		for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin
					color = 8'h00; scroll = 1'b1; tx_idle_pct = 15; rx_idle_pct = 10;
				end
				1: begin
					color = 8'hFF; scroll = 1'b0; tx_idle_pct = 0;  rx_idle_pct = 25;
				end
				2: begin
					color = 8'h5A; scroll = 1'b1; tx_idle_pct = 30; rx_idle_pct = 0;
				end
				3: begin
					color = CFG_DATA_W'($urandom); scroll = 1'b0;
					tx_idle_pct = 10; rx_idle_pct = 40;
				end
				4: begin
					color = 8'hA5; scroll = 1'b1; tx_idle_pct = 0; rx_idle_pct = 0;
				end
				default: begin
					// last stretch: no idling at all
					color = CFG_DATA_W'($urandom); scroll = 1'($urandom);
					quiet_tail = 1'b1;
				end
			endcase
			write_register(CFG_TEXT_COLOR, color);
			write_register(CFG_AUTO_SCROLL, CFG_DATA_W'(scroll));
			run_random_phase(p);
			wait_for_reports();
		end

		// catch any stray report after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
sv/tmcw_pkg.sv
sv/tmcw_req_if.sv
sv/tmcw_rsp_if.sv
sv/tmcw_ram.sv
sv/tmcw_front.sv
sv/tmcw_back.sv
sv/text_mode_console_writer_core.sv
test/text_mode_console_writer_core_tb.sv
